### rtl/core/lbzb_pkg.sv
// lbzb_pkg: shared types and constants of the lidar box zone brake.
// Holds the CORDIC arctangent table, reset values, register indexes and the
// status structs passed between the sequencer, the CORDIC and the zone test.
package lbzb_pkg;

   localparam int CORDIC_ITERS = 16;
   localparam int CORDIC_XW    = 34;   // Q2.30 datapath plus guard bits
   localparam int CORDIC_ZW    = 25;   // angle accumulator, 2^-24 turn units
   localparam logic signed [CORDIC_XW-1:0] CORDIC_X_INIT = 34'sd652032875;

   localparam int PROD_W = 33;         // 16b unsigned range times Q1.15

   // configuration register indexes
   localparam logic [7:0] REG_SAFETY_WIDTH  = 8'd0;
   localparam logic [7:0] REG_SAFETY_LENGTH = 8'd1;
   localparam logic [7:0] REG_ANGLE_MIN     = 8'd2;
   localparam logic [7:0] REG_ANGLE_STEP    = 8'd3;

   localparam logic [15:0] RST_SAFETY_WIDTH  = 16'd1200;
   localparam logic [15:0] RST_SAFETY_LENGTH = 16'd1700;
   localparam logic [15:0] RST_ANGLE_MIN     = 16'h8000;
   localparam logic [15:0] RST_ANGLE_STEP    = 16'd32;

   localparam logic [15:0] RANGE_NO_RETURN = 16'hFFFF;

   // request kinds carried on tuser
   localparam logic KIND_POINT   = 1'b0;
   localparam logic KIND_COMMAND = 1'b1;

   typedef struct packed {
      logic               done;
      logic signed [15:0] sin;
      logic signed [15:0] cos;
   } cordic_rsp_type;

   typedef struct packed {
      logic done;
      logic hit;
   } zone_rsp_type;

   // atan(2^-k) in units of 2^-24 turn
   function automatic logic [CORDIC_ZW-1:0] atan_lut(input logic [3:0] k);
      logic [CORDIC_ZW-1:0] v;
      unique case (k)
         4'd0:  v = 25'd2097152;
         4'd1:  v = 25'd1238021;
         4'd2:  v = 25'd654136;
         4'd3:  v = 25'd332050;
         4'd4:  v = 25'd166669;
         4'd5:  v = 25'd83416;
         4'd6:  v = 25'd41718;
         4'd7:  v = 25'd20860;
         4'd8:  v = 25'd10430;
         4'd9:  v = 25'd5215;
         4'd10: v = 25'd2608;
         4'd11: v = 25'd1304;
         4'd12: v = 25'd652;
         4'd13: v = 25'd326;
         4'd14: v = 25'd163;
         4'd15: v = 25'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/lbzb_cordic.sv
// lbzb_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Folds the binary angle to +-quarter turn, runs 16 steps on a shared
// add/shift unit, then rounds both results to Q1.15. Uses lbzb_pkg.
module lbzb_cordic import lbzb_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [15:0]    angle,
   output cordic_rsp_type rsp
);

   localparam logic [23:0] ANGLE_MASK =
      ~((24'(1) << (24 - ANGLE_BITS)) - 24'(1));

   typedef enum logic [1:0] {C_IDLE, C_ROT, C_ROUND} cstate_type;

   cstate_type                  state_ff;
   logic [3:0]                  step_ff;
   logic signed [CORDIC_XW-1:0] x_ff, y_ff;
   logic signed [CORDIC_ZW-1:0] z_ff;
   logic                        flip_ff;
   logic                        done_ff;
   logic signed [15:0]          sin_ff, cos_ff;

   logic [23:0]                 phase24;
   logic signed [CORDIC_ZW-1:0] z_raw, z_fold;
   logic                        fold;
   logic signed [CORDIC_XW-1:0] x_sh, y_sh, x_in, y_in, x_fin, y_fin;
   logic signed [CORDIC_ZW-1:0] z_in, atan_k;

   function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_XW-1:0] v);
      logic signed [CORDIC_XW:0] sum;
      logic signed [CORDIC_XW:0] r;
      logic signed [15:0]        q;
      sum = {v[CORDIC_XW-1], v} + (CORDIC_XW+1)'(1 << 14);
      r   = sum >>> 15;
      if (r > (CORDIC_XW+1)'(32767))
         q = 16'sh7FFF;
      else if (r < -(CORDIC_XW+1)'(32768))
         q = 16'sh8000;
      else
         q = r[15:0];
      return q;
   endfunction

   // quadrant fold of the incoming angle
   always_comb begin
      phase24 = {angle, 8'h00} & ANGLE_MASK;
      z_raw   = CORDIC_ZW'($signed(phase24));
      fold    = (z_raw > 25'sh400000) || (z_raw < -25'sh400000);
      if (!fold)
         z_fold = z_raw;
      else if (z_raw > 0)
         z_fold = z_raw - 25'sh800000;
      else
         z_fold = z_raw + 25'sh800000;
   end

   // shared micro-rotation unit
   always_comb begin
      atan_k = $signed(atan_lut(step_ff));
      x_sh   = x_ff >>> step_ff;
      y_sh   = y_ff >>> step_ff;
      if (!z_ff[CORDIC_ZW-1]) begin
         x_in = x_ff - y_sh;
         y_in = y_ff + x_sh;
         z_in = z_ff - atan_k;
      end else begin
         x_in = x_ff + y_sh;
         y_in = y_ff - x_sh;
         z_in = z_ff + atan_k;
      end
      x_fin = flip_ff ? -x_ff : x_ff;
      y_fin = flip_ff ? -y_ff : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  x_ff     <= CORDIC_X_INIT;
                  y_ff     <= '0;
                  z_ff     <= z_fold;
                  flip_ff  <= fold;
                  step_ff  <= '0;
                  state_ff <= C_ROT;
               end
            end
            C_ROT: begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               z_ff    <= z_in;
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(CORDIC_ITERS - 1))
                  state_ff <= C_ROUND;
            end
            C_ROUND: begin
               cos_ff   <= to_q15(x_fin);
               sin_ff   <= to_q15(y_fin);
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.sin  = sin_ff;
   assign rsp.cos  = cos_ff;

endmodule

### rtl/core/lbzb_zone.sv
// lbzb_zone: rectangle test of one polar point, x = r*sin, y = r*cos.
// One multiplier is shared by the two axes over consecutive cycles.
// Uses lbzb_pkg.
module lbzb_zone import lbzb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        range_mm,
   input  logic signed [15:0] sin,
   input  logic signed [15:0] cos,
   input  logic [15:0]        width_mm,
   input  logic [15:0]        length_mm,
   output zone_rsp_type       rsp
);

   typedef enum logic [1:0] {Z_IDLE, Z_X, Z_Y, Z_DONE} zstate_type;

   zstate_type               state_ff;
   logic [15:0]              range_ff;
   logic signed [15:0]       sin_ff, cos_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     x_ok_ff;
   logic                     done_ff, hit_ff;

   logic signed [15:0]       mul_b;
   logic signed [PROD_W-1:0] prod;

   // 2*|p| <= lim * 2^15, exact
   function automatic logic in_bound(input logic signed [PROD_W-1:0] p,
                                     input logic [15:0] lim);
      logic [PROD_W-1:0] mag;
      logic [PROD_W:0]   twice, bound;
      mag   = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
      twice = {mag, 1'b0};
      bound = {3'b000, lim, 15'h0000};
      return twice <= bound;
   endfunction

   assign mul_b = (state_ff == Z_X) ? sin_ff : cos_ff;
   assign prod  = $signed({1'b0, range_ff}) * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Z_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            Z_IDLE: begin
               if (start) begin
                  range_ff <= range_mm;
                  sin_ff   <= sin;
                  cos_ff   <= cos;
                  state_ff <= Z_X;
               end
            end
            Z_X: begin
               prod_ff  <= prod;
               state_ff <= Z_Y;
            end
            Z_Y: begin
               prod_ff  <= prod;
               x_ok_ff  <= in_bound(prod_ff, width_mm);
               state_ff <= Z_DONE;
            end
            Z_DONE: begin
               hit_ff   <= x_ok_ff && in_bound(prod_ff, length_mm);
               done_ff  <= 1'b1;
               state_ff <= Z_IDLE;
            end
            default: state_ff <= Z_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.hit  = hit_ff;

endmodule

### rtl/core/lidar_box_zone_brake.sv
// lidar_box_zone_brake: rectangular lidar safety zone with a forward-speed brake.
// Sequence: a velocity command gives its response transaction in the cycle after accept;
//   a scan point with a return and an index in range runs the angle and start states,
//   CORDIC load, 16 steps and rounding, then the shared-multiplier test; no new request
//   is taken until it ends. Other items: one per cycle while the response side is ready.
// Reset: synchronous, active high; registers take their defaults, the scan is safe.
module lidar_box_zone_brake import lbzb_pkg::*; #(
   parameter int MAX_POINTS = 2048,
   parameter int ANGLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // range_mm[15:0], point_index[26:16],
                                    // linear_x[42:27], zero pad [47:43]
   input  logic        req_tuser,   // kind: 0 scan point, 1 velocity command
   input  logic        req_tlast,   // last_point of the scan
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // safe[0], linear_x_out[16:1], zero pad [23:17]
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [1:0] {S_IDLE, S_ANGLE, S_START, S_WORK} state_type;

   // configuration registers
   logic [15:0]        width_ff, length_ff, step_ff;
   logic signed [15:0] amin_ff;

   // sequencer
   state_type          state_ff;
   logic               hit_running_ff, hit_committed_ff;
   logic               last_ff, clear_ff;
   logic [15:0]        range_ff, angle_ff;
   logic [10:0]        index_ff;

   // response holding register
   logic               rsp_valid_ff, rsp_safe_ff;
   logic signed [15:0] rsp_lx_ff;

   logic               req_fire, csr_fire;
   logic [15:0]        req_range;
   logic [10:0]        req_index;
   logic signed [15:0] req_lx;
   logic               eligible;
   logic [26:0]        angle_prod;
   logic               run_base, brake;

   cordic_rsp_type     cordic_rsp;
   zone_rsp_type       zone_rsp;

   assign req_range = req_tdata[15:0];
   assign req_index = req_tdata[26:16];
   assign req_lx    = $signed(req_tdata[42:27]);

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;

   // points without a return or past the scan table never hit
   assign eligible = (req_range != RANGE_NO_RETURN) &&
                     ({21'd0, req_index} < 32'(MAX_POINTS));

   // beam angle, wraps modulo one turn
   assign angle_prod = 27'(step_ff) * 27'(index_ff);

   // hit flag after the index 0 clear
   assign run_base = clear_ff ? 1'b0 : hit_running_ff;

   // brake only positive forward speed
   assign brake = hit_committed_ff && (req_lx > 16'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_SAFETY_WIDTH;
         length_ff <= RST_SAFETY_LENGTH;
         amin_ff   <= $signed(RST_ANGLE_MIN);
         step_ff   <= RST_ANGLE_STEP;
      end else if (csr_fire) begin
         priority case (csr_index)
            REG_SAFETY_WIDTH:  width_ff  <= csr_data;
            REG_SAFETY_LENGTH: length_ff <= csr_data;
            REG_ANGLE_MIN:     amin_ff   <= $signed(csr_data);
            REG_ANGLE_STEP:    step_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         hit_running_ff   <= 1'b0;
         hit_committed_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // a new command response replaces the one drained this cycle
         if (req_fire && req_tuser == KIND_COMMAND)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_tuser == KIND_COMMAND) begin
                     rsp_safe_ff  <= !hit_committed_ff;
                     rsp_lx_ff    <= brake ? 16'sd0 : req_lx;
                  end else if (eligible) begin
                     range_ff <= req_range;
                     index_ff <= req_index;
                     clear_ff <= (req_index == 11'd0);
                     last_ff  <= req_tlast;
                     state_ff <= S_ANGLE;
                  end else begin
                     // no hit possible: clear and commit only
                     if (req_index == 11'd0)
                        hit_running_ff <= 1'b0;
                     if (req_tlast)
                        hit_committed_ff <= (req_index == 11'd0) ? 1'b0 : hit_running_ff;
                  end
               end
            end
            S_ANGLE: begin
               angle_ff <= $unsigned(amin_ff) + angle_prod[15:0];
               state_ff <= S_START;
            end
            S_START: state_ff <= S_WORK;
            S_WORK: begin
               if (zone_rsp.done) begin
                  hit_running_ff <= run_base || zone_rsp.hit;
                  if (last_ff)
                     hit_committed_ff <= run_base || zone_rsp.hit;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   lbzb_cordic #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_START),
      .angle (angle_ff),
      .rsp   (cordic_rsp)
   );

   lbzb_zone u_zone (
      .clock     (clock),
      .reset     (reset),
      .start     (cordic_rsp.done),
      .range_mm  (range_ff),
      .sin       (cordic_rsp.sin),
      .cos       (cordic_rsp.cos),
      .width_mm  (width_ff),
      .length_mm (length_ff),
      .rsp       (zone_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_lx_ff, rsp_safe_ff};

`ifndef SYNTHESIS
   // a command transaction always leaves a response pending
   a_cmd_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == KIND_COMMAND |=> rsp_tvalid)
      else $error("command accepted without a response");

   // CORDIC finishes only while the sequencer waits on it
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cordic_rsp.done |-> state_ff == S_WORK)
      else $error("CORDIC done outside point processing");

   // zone result arrives only while a point is in flight
   a_zone_done: assert property (@(posedge clock) disable iff (reset)
      zone_rsp.done |-> state_ff == S_WORK && $past(cordic_rsp.done, 4))
      else $error("zone result out of sequence");

   // committed flag moves only on a point transaction or a finished test
   a_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(hit_committed_ff) |->
         $past(reset) || $past(req_fire) || $past(zone_rsp.done))
      else $error("committed hit flag changed without a scan point");
`endif

endmodule

### test/zone_brake_checker_pkg.sv
// Scoreboard for the lidar box zone brake: a bit-exact predictor of the scan
// hit flags and the braked speed, plus the queue of responses still due.
// Depends on lbzb_pkg for reset values, register indexes and request kinds.
package zone_brake_checker_pkg;
   import lbzb_pkg::*;

   localparam int     BEAM_SLOTS   = 2048;
   localparam longint HALF_TURN    = 8388608;    // 2^-24 turn units
   localparam longint QUARTER_TURN = 4194304;
   localparam longint FULL_TURN    = 16777216;
   localparam longint CORDIC_GAIN  = 652032875;  // 0.607252935 in Q2.30

   // atan(2^-k), 2^-24 turn units
   localparam int TURN24_ATAN [16] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81
   };

   typedef struct {
      logic               safe;
      logic signed [15:0] speed;
   } speed_result_type;

   class zone_brake_checker;
      logic [15:0]      zone_width;
      logic [15:0]      zone_length;
      logic [15:0]      angle_first;
      logic [15:0]      angle_pitch;
      bit               hit_running;
      bit               hit_committed;
      speed_result_type pending_speed[$];
      int               mismatches;

      function new();
         zone_width    = RST_SAFETY_WIDTH;
         zone_length   = RST_SAFETY_LENGTH;
         angle_first   = RST_ANGLE_MIN;
         angle_pitch   = RST_ANGLE_STEP;
         hit_running   = 1'b0;
         hit_committed = 1'b0;
         mismatches    = 0;
      endfunction

      function void write_reg(logic [7:0] idx, logic [15:0] val);
         case (idx)
            REG_SAFETY_WIDTH:  zone_width  = val;
            REG_SAFETY_LENGTH: zone_length = val;
            REG_ANGLE_MIN:     angle_first = val;
            REG_ANGLE_STEP:    angle_pitch = val;
            default: ;
         endcase
      endfunction

      // round half up to Q1.15 and saturate
      function int round_q15(longint v);
         longint r;
         r = (v + 16384) >>> 15;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return int'(r);
      endfunction

      function void beam_sin_cos(input logic [15:0] ang, output int sin_q15,
                                 output int cos_q15);
         longint phase, x, y, t;
         bit     flip;
         phase = longint'({ang, 8'h00});
         if (phase >= HALF_TURN) phase = phase - FULL_TURN;
         flip = 1'b0;
         // fold into +-quarter turn, negate both outputs afterwards
         if (phase > QUARTER_TURN || phase < -QUARTER_TURN) begin
            phase = (phase > 0) ? phase - HALF_TURN : phase + HALF_TURN;
            flip  = 1'b1;
         end
         x = CORDIC_GAIN;
         y = 0;
         for (int k = 0; k < 16; k++) begin
            if (phase >= 0) begin
               t = x - (y >>> k);
               y = y + (x >>> k);
               phase = phase - TURN24_ATAN[k];
            end else begin
               t = x + (y >>> k);
               y = y - (x >>> k);
               phase = phase + TURN24_ATAN[k];
            end
            x = t;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         cos_q15 = round_q15(x);
         sin_q15 = round_q15(y);
      endfunction

      // exact rectangle test on range * sin/cos, no rounding of x or y
      function bit beam_in_zone(logic [15:0] rng, logic [10:0] idx);
         logic [15:0] ang;
         int          s, c;
         longint      px, py;
         if (rng == RANGE_NO_RETURN || idx >= BEAM_SLOTS) return 1'b0;
         ang = angle_first + angle_pitch * idx;
         beam_sin_cos(ang, s, c);
         px = longint'(rng) * s;
         py = longint'(rng) * c;
         if (px < 0) px = -px;
         if (py < 0) py = -py;
         return (2 * px <= (longint'(zone_width) << 15)) &&
                (2 * py <= (longint'(zone_length) << 15));
      endfunction

      function void note_request(logic kind, logic [15:0] rng, logic [10:0] idx,
                                 logic last, logic signed [15:0] speed);
         speed_result_type res;
         if (kind == KIND_POINT) begin
            if (idx == 0) hit_running = 1'b0;
            if (beam_in_zone(rng, idx)) hit_running = 1'b1;
            if (last) hit_committed = hit_running;
         end else begin
            res.safe  = !hit_committed;
            res.speed = (hit_committed && speed > 0) ? 16'sd0 : speed;
            pending_speed.insert(pending_speed.size(), res);
         end
      endfunction

      function void check_response(logic [23:0] data);
         logic               got_safe;
         logic signed [15:0] got_speed;
         speed_result_type   want;
         got_safe  = data[0];
         got_speed = data[16:1];
         if (pending_speed.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual safe=%0d speed=%0d",
                     $time, got_safe, got_speed);
            mismatches++;
            return;
         end
         want = pending_speed.pop_front();
         if (got_safe !== want.safe) begin
            $display("%0t: safe mismatch, expected %0d actual %0d",
                     $time, want.safe, got_safe);
            mismatches++;
         end
         if (got_speed !== want.speed) begin
            $display("%0t: linear_x_out mismatch, expected %0d actual %0d",
                     $time, want.speed, got_speed);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_speed.size();
      endfunction
   endclass

endpackage

### test/testbench.sv
// Top-level testbench of lidar_box_zone_brake: directed and random scans and
// velocity commands over eight register settings and four back-pressure mixes.
// Depends on lbzb_pkg and zone_brake_checker_pkg.
module testbench;
   import lbzb_pkg::*;
   import zone_brake_checker_pkg::*;

   localparam int IDLE_LIMIT      = 2000;  // cycles with no transaction at all
   localparam int SETTLE_CYCLES   = 40;    // time for a point in flight to finish
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 130;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // range_mm[15:0], point_index[26:16], linear_x[42:27]
   logic        req_tuser;    // kind
   logic        req_tlast;    // last_point
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;    // safe[0], linear_x_out[16:1]
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   zone_brake_checker brake_check = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;
   int items_sent     = 0;

   lidar_box_zone_brake uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random stalls, changed on the falling edge only.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Response check and watchdog, sampled on the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) brake_check.check_response(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // One request transaction. Entered and left just after a falling edge; the
   // valid stays high into the next call so back-to-back items need no gap.
   task automatic send_item(input logic kind, input logic [15:0] rng,
                            input logic [10:0] idx, input logic last,
                            input logic [15:0] speed);
      bit accepted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {5'b0, speed, idx, rng};
      req_tuser  = kind;
      req_tlast  = last;
      req_tvalid = 1'b1;
      accepted   = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = req_tready;
         if (accepted) brake_check.note_request(kind, rng, idx, last, speed);
         @(negedge clock);
      end
      items_sent++;
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      bit accepted;
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1'b1;
      accepted  = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = csr_ready;
         if (accepted) brake_check.write_reg(idx, val);
         @(negedge clock);
      end
      csr_valid = 1'b0;
   endtask

   // Wait for every response, then let any point still in the CORDIC finish.
   task automatic settle();
      req_tvalid = 1'b0;
      while (brake_check.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Ranges weighted toward the zone size so hits and misses both occur.
   function automatic logic [15:0] pick_range();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15) return RANGE_NO_RETURN;
      if (sel < 25) return 16'($urandom_range(0, 50));
      if (sel < 75) return 16'($urandom_range(0, 2500));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hFFFF;
         3: return 16'h7FFF;
         4: return 16'h8000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Well-formed scan: index 0 first, increasing indices, last on the end,
   // followed by a few commands that read the committed result.
   task automatic send_scan_and_commands();
      int n, stride, cmds;
      n      = $urandom_range(1, 12);
      stride = ($urandom_range(2) == 0) ? 1 : $urandom_range(1, 2047 / n);
      for (int k = 0; k < n; k++) begin
         send_item(KIND_POINT, pick_range(), 11'(k * stride), k == n - 1,
                   16'($urandom_range(0, 65535)));
      end
      cmds = $urandom_range(1, 3);
      repeat (cmds) begin
         send_item(KIND_COMMAND, 16'($urandom_range(0, 65535)),
                   11'($urandom_range(0, 2047)), 1'($urandom_range(1)), pick_speed());
      end
   endtask

   // Noise: lone points with any index or last flag, or stray commands.
   task automatic send_noise();
      send_item(1'($urandom_range(1)), pick_range(), 11'($urandom_range(0, 2047)),
                1'($urandom_range(1)), pick_speed());
   endtask

   // Directed part, run with the reset register values: beam 0 points
   // backward, beam 1024 straight ahead, beam 2047 just left of backward.
   task automatic run_directed();
      // command before any scan: committed flag clear, speed passes
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h7FFF);
      // scan with a close hit, a no-return beam and a zero range on the end
      send_item(KIND_POINT, 16'd100, 11'd0, 1'b0, 16'h0000);
      send_item(KIND_POINT, RANGE_NO_RETURN, 11'd1024, 1'b0, 16'hFFFF);
      send_item(KIND_POINT, 16'd0, 11'd2047, 1'b1, 16'h0000);
      // unsafe: positive speeds brake, zero and reverse pass
      send_item(KIND_COMMAND, 16'hFFFF, 11'd2047, 1'b1, 16'h7FFF);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h0001);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h0000);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'hFFFF);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h8000);
      // one-point scan with no return still clears and commits: safe again
      send_item(KIND_POINT, RANGE_NO_RETURN, 11'd0, 1'b1, 16'h0000);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h0064);
      // forward beam right at the zone edge, far beam out of zone
      send_item(KIND_POINT, 16'd5000, 11'd0, 1'b0, 16'h0000);
      send_item(KIND_POINT, 16'hFFFE, 11'd512, 1'b0, 16'h0000);
      send_item(KIND_POINT, 16'd849, 11'd1024, 1'b1, 16'h0000);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h7FFF);
      // just past the edge: miss
      send_item(KIND_POINT, 16'd851, 11'd1024, 1'b1, 16'h0000);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h7FFF);
      // scan never closed: committed flag keeps the old value
      send_item(KIND_POINT, 16'd10, 11'd0, 1'b0, 16'h0000);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h1234);
      send_item(KIND_POINT, 16'd10, 11'd1365, 1'b1, 16'h0000);
      send_item(KIND_COMMAND, 16'h0000, 11'd0, 1'b0, 16'h1234);
   endtask

   task automatic load_phase_regs(input int phase);
      logic [15:0] w, l, a0, da;
      case (phase)
         1:       begin w = 16'd0;     l = 16'hFFFF;  a0 = 16'h0000; da = 16'h4000; end
         2:       begin w = 16'hFFFF;  l = 16'd0;     a0 = 16'h8000; da = 16'hFFFF; end
         3:       begin w = 16'hFFFF;  l = 16'hFFFF;  a0 = 16'h7FFF; da = 16'h0000; end
         4:       begin
            w  = 16'($urandom_range(0, 3000));
            l  = 16'($urandom_range(0, 3000));
            a0 = 16'($urandom_range(0, 65535));
            da = 16'($urandom_range(0, 64));
         end
         5:       begin w = 16'd2000;  l = 16'd1000;  a0 = 16'h4000; da = 16'h0001; end
         6:       begin
            w  = 16'($urandom_range(0, 65535));
            l  = 16'($urandom_range(0, 65535));
            a0 = 16'($urandom_range(0, 65535));
            da = 16'($urandom_range(0, 65535));
         end
         default: begin w = 16'd800;   l = 16'd3000;  a0 = 16'hC000; da = 16'h0800; end
      endcase
      write_reg(REG_SAFETY_WIDTH, w);
      write_reg(REG_SAFETY_LENGTH, l);
      write_reg(REG_ANGLE_MIN, a0);
      write_reg(REG_ANGLE_STEP, da);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_POINT;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = REG_SAFETY_WIDTH;
      csr_data   = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         // back-pressure mix: none, sender idle, receiver stall, both
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         if (phase == 0) begin
            run_directed();
         end else begin
            // registers change only with the block idle
            settle();
            load_phase_regs(phase);
         end
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 75) send_scan_and_commands();
            else send_noise();
         end
      end

      settle();
      if (brake_check.mismatches == 0 && brake_check.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/lbzb_pkg.sv
rtl/core/lbzb_cordic.sv
rtl/core/lbzb_zone.sv
rtl/core/lidar_box_zone_brake.sv
test/zone_brake_checker_pkg.sv
test/testbench.sv
